// ----- hw/rtl/ksv_pkg.sv -----
// ----------------------------------------------------------------------------
// Key strike velocity meter package
// Shared types and constants of the velocity meter.
// ----------------------------------------------------------------------------
package ksv_pkg;

  localparam int unsigned KeyW  = 4;
  localparam int unsigned PosW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned VelW  = 7;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned XW    = 15;
  localparam int unsigned ProdW = 44;

  localparam logic [TimeW-1:0] MinDtUs  = 32'd500;
  localparam logic [TimeW-1:0] MaxDtUs  = 32'd30000;
  // 127 * ceil(2^37 / 29500): exact floor(x * 127 / 29500) for x <= 29500
  localparam logic [29:0]      VelRecip = 30'd591686396;
  localparam int unsigned      VelShift = 37;

  localparam logic [CfgW-1:0] StartThrReset = 16'd12;
  localparam logic [CfgW-1:0] EndThrReset   = 16'd40;

  typedef enum logic [0:0] {
    CFG_START_THR = 1'b0,
    CFG_END_THR   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             armed;
    logic             started;
    logic [TimeW-1:0] start_time;
    logic [VelW-1:0]  velocity;
  } key_entry_t;

endpackage

// ----- hw/rtl/ksv_state_mem.sv -----
// ----------------------------------------------------------------------------
// Key state memory
// One entry per key, synchronous write, registered read; entries read as
// zero until first written.
// ----------------------------------------------------------------------------
module ksv_state_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output ksv_pkg::key_entry_t rd_data_o,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  ksv_pkg::key_entry_t wr_data_i
);

  ksv_pkg::key_entry_t mem_q [Depth];
  logic [Depth-1:0]    valid_q;
  ksv_pkg::key_entry_t rd_data_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- hw/rtl/ksv_vel_unit.sv -----
// ----------------------------------------------------------------------------
// Velocity unit
// Clamp the strike time, register it, then scale to a 0..127 velocity.
// ----------------------------------------------------------------------------
module ksv_vel_unit (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic [ksv_pkg::TimeW-1:0]   dt_i,
  output logic [ksv_pkg::VelW-1:0]    velocity_o
);

  logic [ksv_pkg::XW-1:0]    x_d, x_q;
  logic [ksv_pkg::TimeW-1:0] dt_clamped;
  logic [ksv_pkg::ProdW-1:0] prod;

  always_comb begin
    if (dt_i < ksv_pkg::MinDtUs) begin
      dt_clamped = ksv_pkg::MinDtUs;
    end else if (dt_i > ksv_pkg::MaxDtUs) begin
      dt_clamped = ksv_pkg::MaxDtUs;
    end else begin
      dt_clamped = dt_i;
    end
    x_d = ksv_pkg::XW'(ksv_pkg::MaxDtUs - dt_clamped);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= x_d;
    end
  end

  assign prod       = ksv_pkg::ProdW'(x_q) * ksv_pkg::ProdW'(ksv_pkg::VelRecip);
  assign velocity_o = prod[ksv_pkg::VelShift +: ksv_pkg::VelW];

endmodule

// ----- hw/rtl/key_strike_velocity_meter.sv -----
// ----------------------------------------------------------------------------
// Key strike velocity meter
// Per-key strike velocity from hall-sensor position samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry key_index, position and time_us; each accepted word
//   yields exactly one output word with key_out, key_velocity and
//   strike_done. Words are accepted when in_valid_i is high and in_stall_o
//   low; output words leave when out_valid_o is high and out_stall_i low.
//   Each result passes through the evaluate and write-back states into the
//   output register; a new word is taken only once the read, evaluate and
//   write-back passes over the per-key state memory for the last one end.
//   A finished word waits in the output register while the next input word
//   is taken; a stalled receiver holds the block at write-back once a second
//   result is ready.
//   Thresholds are written through cfg_we_i/cfg_index_i/cfg_data_i while
//   the block is idle.
//   Reset clears all keys to idle with velocity zero and loads thresholds
//   12 and 40; no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_strike_velocity_meter #(
  parameter int unsigned KEY_COUNT = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_index_i,
  input  logic [ksv_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ksv_pkg::KeyW-1:0]    key_index_i,
  input  logic [ksv_pkg::PosW-1:0]    position_i,
  input  logic [ksv_pkg::TimeW-1:0]   time_us_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ksv_pkg::KeyW-1:0]    key_out_o,
  output logic [ksv_pkg::VelW-1:0]    key_velocity_o,
  output logic                        strike_done_o
);

  localparam int unsigned AddrW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned WideW = AddrW + ksv_pkg::KeyW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_WB   = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ksv_pkg::CfgW-1:0] start_thr_q, end_thr_q;

  logic [ksv_pkg::KeyW-1:0]  key_q;
  logic [ksv_pkg::PosW-1:0]  pos_q;
  logic [ksv_pkg::TimeW-1:0] time_q;
  logic                      in_range_q;

  logic                      done_q;
  ksv_pkg::key_entry_t       entry_q;
  ksv_pkg::key_entry_t       entry_d;
  logic                      done_d;

  logic                      out_valid_q;
  logic [ksv_pkg::KeyW-1:0]  out_key_q;
  logic [ksv_pkg::VelW-1:0]  out_vel_q;
  logic                      out_done_q;

  logic                      in_fire;
  logic                      wb_fire;
  logic [WideW-1:0]          key_in_wide;
  logic [WideW-1:0]          key_q_wide;
  ksv_pkg::key_entry_t       rd_entry;
  ksv_pkg::key_entry_t       wr_entry;
  logic [ksv_pkg::VelW-1:0]  calc_vel;
  logic [ksv_pkg::VelW-1:0]  final_vel;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && (state_q == ST_IDLE);
  assign wb_fire     = (state_q == ST_WB) && (!out_valid_q || !out_stall_i);
  assign key_in_wide = WideW'(key_index_i);
  assign key_q_wide  = WideW'(key_q);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q <= ksv_pkg::StartThrReset;
      end_thr_q   <= ksv_pkg::EndThrReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ksv_pkg::CFG_START_THR: start_thr_q <= cfg_data_i;
        ksv_pkg::CFG_END_THR:   end_thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ksv_state_mem #(
    .Depth (KEY_COUNT),
    .AddrW (AddrW)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (key_in_wide[AddrW-1:0]),
    .rd_data_o (rd_entry),
    .wr_en_i   (wb_fire && in_range_q),
    .wr_addr_i (key_q_wide[AddrW-1:0]),
    .wr_data_i (wr_entry)
  );

  ksv_vel_unit u_vel_unit (
    .clk_i      (clk_i),
    .load_i     (state_q == ST_EVAL),
    .dt_i       (time_q - rd_entry.start_time),
    .velocity_o (calc_vel)
  );

  // per-key stage update
  always_comb begin
    entry_d = rd_entry;
    done_d  = 1'b0;
    if (!rd_entry.armed) begin
      if (pos_q < start_thr_q) begin
        entry_d.armed = 1'b1;
      end
    end else if (!rd_entry.started) begin
      if (pos_q > start_thr_q) begin
        entry_d.started    = 1'b1;
        entry_d.start_time = time_q;
      end
    end else if (pos_q > end_thr_q) begin
      entry_d.armed      = 1'b0;
      entry_d.started    = 1'b0;
      entry_d.start_time = '0;
      done_d             = in_range_q;
    end
  end

  assign final_vel = done_q ? calc_vel : entry_q.velocity;

  always_comb begin
    wr_entry          = entry_q;
    wr_entry.velocity = final_vel;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EVAL;
      ST_EVAL: state_d = ST_WB;
      ST_WB:   if (wb_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wb_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q      <= key_index_i;
      pos_q      <= position_i;
      time_q     <= time_us_i;
      in_range_q <= (32'(key_index_i) < KEY_COUNT);
    end
    if (state_q == ST_EVAL) begin
      entry_q <= entry_d;
      done_q  <= done_d;
    end
    if (wb_fire) begin
      out_key_q  <= key_q;
      out_vel_q  <= in_range_q ? final_vel : '0;
      out_done_q <= done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_out_o      = out_key_q;
  assign key_velocity_o = out_vel_q;
  assign strike_done_o  = out_done_q;

endmodule

// ----- tb/sv/ksv_velocity_checker.sv -----
// ----------------------------------------------------------------------------
// Key strike velocity checker
// Watches the sample and result channels of the velocity meter, keeps its own
// per-key strike state, predicts one result word per accepted sample and
// compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ksv_velocity_checker #(
  parameter int unsigned KEY_COUNT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_index_i,
  input  logic [ksv_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [ksv_pkg::KeyW-1:0]  key_index_i,
  input  logic [ksv_pkg::PosW-1:0]  position_i,
  input  logic [ksv_pkg::TimeW-1:0] time_us_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [ksv_pkg::KeyW-1:0]  key_out_i,
  input  logic [ksv_pkg::VelW-1:0]  key_velocity_i,
  input  logic                      strike_done_i,
  output int unsigned               mismatches_o,
  output int unsigned               awaited_o
);

  localparam logic [ksv_pkg::TimeW-1:0] TopVelocity = 32'd127;

  typedef struct packed {
    logic [ksv_pkg::KeyW-1:0] key;
    logic [ksv_pkg::VelW-1:0] velocity;
    logic                     done;
  } key_reading_t;

  logic [ksv_pkg::CfgW-1:0]  start_thr;
  logic [ksv_pkg::CfgW-1:0]  end_thr;
  logic                      armed     [KEY_COUNT];
  logic                      timing    [KEY_COUNT];
  logic [ksv_pkg::TimeW-1:0] strike_t0 [KEY_COUNT];
  logic [ksv_pkg::VelW-1:0]  key_vel   [KEY_COUNT];
  key_reading_t              readings_due[$];
  int unsigned               mismatches;

  function automatic logic [ksv_pkg::VelW-1:0] velocity_of(logic [ksv_pkg::TimeW-1:0] dt);
    logic [ksv_pkg::TimeW-1:0] span;
    span = dt;
    if (span < ksv_pkg::MinDtUs) span = ksv_pkg::MinDtUs;
    if (span > ksv_pkg::MaxDtUs) span = ksv_pkg::MaxDtUs;
    return ksv_pkg::VelW'(((ksv_pkg::MaxDtUs - span) * TopVelocity) /
                          (ksv_pkg::MaxDtUs - ksv_pkg::MinDtUs));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_reading_t             want;
    key_reading_t             got;
    logic [ksv_pkg::KeyW-1:0] k;
    if (!rst_ni) begin
      start_thr = ksv_pkg::StartThrReset;
      end_thr   = ksv_pkg::EndThrReset;
      for (int i = 0; i < KEY_COUNT; i++) begin
        armed[i]     = 1'b0;
        timing[i]    = 1'b0;
        strike_t0[i] = '0;
        key_vel[i]   = '0;
      end
      readings_due.delete();
      mismatches = 0;
      mismatches_o <= 0;
      awaited_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ksv_pkg::CFG_START_THR: start_thr = cfg_data_i;
          ksv_pkg::CFG_END_THR:   end_thr   = cfg_data_i;
          default: ;
        endcase
      end

      // compare the outgoing word before queuing the new prediction
      if (out_valid_i && !out_stall_i) begin
        got = '{key: key_out_i, velocity: key_velocity_i, done: strike_done_i};
        if (readings_due.size() == 0) begin
          $error("key_out: no word awaited, got %0d", got.key);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          if (got.key != want.key) begin
            $error("key_out: expected %0d, got %0d", want.key, got.key);
            mismatches++;
          end
          if (got.velocity != want.velocity) begin
            $error("key_velocity: expected %0d, got %0d", want.velocity, got.velocity);
            mismatches++;
          end
          if (got.done != want.done) begin
            $error("strike_done: expected %0d, got %0d", want.done, got.done);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        k    = key_index_i;
        want = '{key: k, velocity: '0, done: 1'b0};
        if (k < KEY_COUNT) begin
          if (!armed[k]) begin
            if (position_i < start_thr) armed[k] = 1'b1;
          end else if (!timing[k]) begin
            if (position_i > start_thr) begin
              timing[k]    = 1'b1;
              strike_t0[k] = time_us_i;
            end
          end else if (position_i > end_thr) begin
            key_vel[k]   = velocity_of(time_us_i - strike_t0[k]);
            timing[k]    = 1'b0;
            armed[k]     = 1'b0;
            strike_t0[k] = '0;
            want.done    = 1'b1;
          end
          want.velocity = key_vel[k];
        end
        readings_due.push_back(want);
      end

      mismatches_o <= mismatches;
      awaited_o    <= readings_due.size();
    end
  end

endmodule

// ----- tb/sv/key_strike_velocity_meter_tb.sv -----
// ----------------------------------------------------------------------------
// Key strike velocity meter testbench
// Drives directed and random key position samples through the meter under
// several threshold settings, with random sender gaps and receiver stalls,
// and leaves prediction and comparison to the velocity checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module key_strike_velocity_meter_tb;

  localparam int unsigned KeyCount  = 16;
  localparam int unsigned WordCount = 800;
  localparam int unsigned PhaseCnt  = 8;
  localparam int unsigned QuietMax  = 2000;

  logic                      clk_i;
  logic                      rst_ni       = 1'b0;
  logic                      cfg_we       = 1'b0;
  logic [0:0]                cfg_index    = ksv_pkg::CFG_START_THR;
  logic [ksv_pkg::CfgW-1:0]  cfg_data     = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic [ksv_pkg::KeyW-1:0]  key_index    = '0;
  logic [ksv_pkg::PosW-1:0]  position     = '0;
  logic [ksv_pkg::TimeW-1:0] time_us      = '0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic [ksv_pkg::KeyW-1:0]  key_out;
  logic [ksv_pkg::VelW-1:0]  key_velocity;
  logic                      strike_done;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned sent;
  int unsigned quiet;
  int unsigned stall_left;
  bit          gaps_on;
  bit          stalls_on;
  logic [ksv_pkg::CfgW-1:0] cur_start;
  logic [ksv_pkg::CfgW-1:0] cur_end;

  key_strike_velocity_meter #(
    .KEY_COUNT(KeyCount)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .key_index_i   (key_index),
    .position_i    (position),
    .time_us_i     (time_us),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .key_out_o     (key_out),
    .key_velocity_o(key_velocity),
    .strike_done_o (strike_done)
  );

  ksv_velocity_checker #(
    .KEY_COUNT(KeyCount)
  ) i_velocity_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .key_index_i   (key_index),
    .position_i    (position),
    .time_us_i     (time_us),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .key_out_i     (key_out),
    .key_velocity_i(key_velocity),
    .strike_done_i (strike_done),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QuietMax) begin
      $display("key_strike_velocity_meter_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(7, 0) == 0) begin
      stall_left = $urandom_range(17, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [ksv_pkg::PosW-1:0] pos_below(logic [ksv_pkg::CfgW-1:0] thr);
    if (thr == '0) return '0;
    return ksv_pkg::PosW'($urandom_range(thr - 1, 0));
  endfunction

  function automatic logic [ksv_pkg::PosW-1:0] pos_above(logic [ksv_pkg::CfgW-1:0] thr);
    if (thr == '1) return '1;
    return ksv_pkg::PosW'($urandom_range(16'hFFFF, thr + 1));
  endfunction

  task automatic send_word(logic [ksv_pkg::KeyW-1:0]  k,
                           logic [ksv_pkg::PosW-1:0]  p,
                           logic [ksv_pkg::TimeW-1:0] t);
    if (gaps_on && $urandom_range(5, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    key_index <= k;
    position  <= p;
    time_us   <= t;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_noise();
    send_word(ksv_pkg::KeyW'($urandom_range(KeyCount - 1, 0)), ksv_pkg::PosW'($urandom()),
              $urandom());
  endtask

  // hold the sender until every result word is back, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(ksv_pkg::cfg_idx_e idx, logic [ksv_pkg::CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == ksv_pkg::CFG_START_THR) cur_start = data;
    else cur_end = data;
  endtask

  // arm, start and end one key, with hovering words and stray words between
  task automatic strike(logic [ksv_pkg::KeyW-1:0] k);
    logic [ksv_pkg::TimeW-1:0] t0;
    logic [ksv_pkg::TimeW-1:0] dt;
    t0 = $urandom();
    case ($urandom_range(5, 0))
      0:       dt = $urandom_range(499, 0);
      1, 2:    dt = $urandom_range(30000, 500);
      3:       dt = $urandom_range(40000, 29000);
      4:       dt = $urandom();
      default: dt = $urandom_range(600, 400);
    endcase
    send_word(k, pos_below(cur_start), $urandom());
    repeat ($urandom_range(2, 0)) begin
      if ($urandom_range(3, 0) == 0) send_noise();
      send_word(k, ksv_pkg::PosW'($urandom_range(cur_start, 0)), $urandom());
    end
    send_word(k, pos_above(cur_start), t0);
    repeat ($urandom_range(2, 0)) begin
      if ($urandom_range(3, 0) == 0) send_noise();
      send_word(k, ksv_pkg::PosW'($urandom_range(cur_end, 0)), t0 + $urandom_range(dt, 0));
    end
    if ($urandom_range(3, 0) == 0) send_noise();
    send_word(k, pos_above(cur_end), t0 + dt);
  endtask

  initial begin
    int unsigned phase_end;
    logic [ksv_pkg::CfgW-1:0] lo;
    cur_start = ksv_pkg::StartThrReset;
    cur_end   = ksv_pkg::EndThrReset;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // thresholds 12 and 40: equal positions change nothing
    send_word(4'd0, 16'd12, 32'd5);
    send_word(4'd0, 16'd11, 32'd6);
    send_word(4'd0, 16'd12, 32'd7);
    send_word(4'd0, 16'd13, 32'd0);
    send_word(4'd0, 16'd40, 32'd100);
    send_word(4'd0, 16'd41, 32'd200);
    // wrapped timestamp, elapsed time above the top clamp
    send_word(4'd15, 16'd0, 32'hFFFF_FF00);
    send_word(4'd15, 16'hFFFF, 32'hFFFF_FFF0);
    send_word(4'd15, 16'hFFFF, 32'd29990);
    // wrapped timestamp inside the range
    send_word(4'd10, 16'd0, 32'hA5A5_5A5A);
    send_word(4'd10, 16'd30, 32'hFFFF_FE00);
    send_word(4'd10, 16'd41, 32'd100);
    // mid range, then the stored velocity on an idle key
    send_word(4'd5, 16'd0, 32'd10);
    send_word(4'd5, 16'd20, 32'd1000);
    send_word(4'd5, 16'd41, 32'd16250);
    send_word(4'd5, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(4'd5, 16'h5555, 32'h5555_5555);
    send_word(4'd7, 16'hAAAA, 32'hAAAA_AAAA);
    // both clamp edges exactly
    send_word(4'd3, 16'd0, 32'd0);
    send_word(4'd3, 16'd13, 32'd1000);
    send_word(4'd3, 16'd41, 32'd1500);
    send_word(4'd3, 16'd0, 32'd0);
    send_word(4'd3, 16'd13, 32'd2000);
    send_word(4'd3, 16'd41, 32'd32000);

    for (int ph = 0; ph < PhaseCnt; ph++) begin
      settle();
      case (ph)
        1: begin
          cfg_write(ksv_pkg::CFG_START_THR, 16'd0);
          cfg_write(ksv_pkg::CFG_END_THR, 16'hFFFF);
        end
        2: begin
          cfg_write(ksv_pkg::CFG_START_THR, 16'hFFFF);
          cfg_write(ksv_pkg::CFG_END_THR, 16'd0);
        end
        3: begin
          cfg_write(ksv_pkg::CFG_START_THR, 16'd40000);
          cfg_write(ksv_pkg::CFG_END_THR, 16'd2000);
        end
        5: begin
          lo = ksv_pkg::CfgW'($urandom_range(2000, 1));
          cfg_write(ksv_pkg::CFG_START_THR, lo);
          cfg_write(ksv_pkg::CFG_END_THR, ksv_pkg::CfgW'(lo + $urandom_range(5000, 1)));
        end
        7: begin
          cfg_write(ksv_pkg::CFG_START_THR, ksv_pkg::StartThrReset);
          cfg_write(ksv_pkg::CFG_END_THR, ksv_pkg::EndThrReset);
        end
        4, 6: begin
          cfg_write(ksv_pkg::CFG_START_THR, ksv_pkg::CfgW'($urandom()));
          cfg_write(ksv_pkg::CFG_END_THR, ksv_pkg::CfgW'($urandom()));
        end
        default: ;
      endcase
      gaps_on   = (ph == 0) || (ph != PhaseCnt - 1 && $urandom_range(2, 0) != 0);
      stalls_on = (ph == 0) || (ph != PhaseCnt - 1 && $urandom_range(2, 0) != 0);
      phase_end = sent + WordCount / PhaseCnt;
      while (sent < phase_end) begin
        if ($urandom_range(4, 0) == 0) send_noise();
        else strike(ksv_pkg::KeyW'($urandom_range(KeyCount - 1, 0)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("key_strike_velocity_meter_tb: clean");
    end else begin
      $display("key_strike_velocity_meter_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ksv_pkg.sv
hw/rtl/ksv_state_mem.sv
hw/rtl/ksv_vel_unit.sv
hw/rtl/key_strike_velocity_meter.sv
tb/sv/ksv_velocity_checker.sv
tb/sv/key_strike_velocity_meter_tb.sv
